>>> rtl/smprd_pkg.sv
// Shared types and constants for the receive chunk deframer.
// No dependencies; imported by smprd_ctrl, smprd_dpath and the top level.
`timescale 1ns / 1ps

package smprd_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_PARITY = 3'd1;
    localparam logic [2:0] ST_HDRBAD = 3'd2;
    localparam logic [2:0] ST_LONG   = 3'd3;
    localparam logic [2:0] ST_SHORT  = 3'd4;

    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW    = 4;
    localparam int WC_W        = 5;
    localparam int LEN_W       = 11;
    localparam int FLS_W       = 12;
    localparam int FOOT_POS_W  = 7;

    localparam logic [LEN_W-1:0] MAX_FRAME_RST = 11'd1536;

    // Footer bit positions
    localparam int FT_HB  = 30;
    localparam int FT_DV  = 21;
    localparam int FT_SV  = 20;
    localparam int FT_SWO = 16;
    localparam int FT_EV  = 14;
    localparam int FT_EBO = 8;

    typedef struct packed {
        logic wr_word;
        logic take_footer;
        logic load_plan;
        logic load_ptr;
        logic emit;
        logic emit_err;
        logic err_long;
        logic next_seg;
    } smprd_cmd_t;

    typedef struct packed {
        logic chk_err;
        logic no_data;
        logic too_long;
        logic last_byte;
        logic more_seg;
        logic out_free;
    } smprd_stat_t;

endpackage

>>> rtl/smprd_dpath.sv
// Datapath of the receive chunk deframer: chunk store, footer decode,
// segment pointers, frame length tracking and the output register.
// Depends on smprd_pkg.
`timescale 1ns / 1ps

module smprd_dpath
    import smprd_pkg::*;
#(
    parameter int CHUNK_BYTES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       chunk_word,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    input  smprd_cmd_t        cmd,
    output smprd_stat_t       stat,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        data_byte,
    output logic              frame_end,
    output logic [2:0]        status,
    output logic              run_last
);

    localparam int CHUNK_WORDS = CHUNK_BYTES / 4;
    localparam int POS_W       = $clog2(CHUNK_BYTES + 1);

    localparam logic [WC_W-1:0]       CW_CNT    = WC_W'(CHUNK_WORDS);
    localparam logic [POS_W-1:0]      CHUNK_POS = POS_W'(CHUNK_BYTES);
    localparam logic [FOOT_POS_W-1:0] CHUNK_P7  = FOOT_POS_W'(CHUNK_BYTES);

    logic [31:0]        store_mem [STORE_DEPTH];
    logic [31:0]        rd_data_reg;
    logic [WC_W-1:0]    wc_reg;
    logic [31:0]        footer_reg;
    logic               full_reg;
    logic               in_frame_reg;
    logic [LEN_W-1:0]   fl_reg;
    logic [LEN_W-1:0]   max_reg;
    logic [2:0]         err_code_reg;
    logic [POS_W-1:0]   lo_reg;
    logic [POS_W-1:0]   hi_reg;
    logic               close_reg;
    logic               seg2_reg;
    logic [POS_W-1:0]   sbo_reg;
    logic [POS_W-1:0]   ptr_reg;
    logic [POS_W-1:0]   ptr_next;
    logic               out_valid_reg;
    logic [7:0]         data_reg;
    logic               end_reg;
    logic [2:0]         status_reg;
    logic               last_reg;

    logic [2:0]            chk_code;
    logic [FOOT_POS_W-1:0] swo_p7;
    logic [FOOT_POS_W-1:0] sbo_p7;
    logic [FOOT_POS_W-1:0] ebo_p7;
    logic [FOOT_POS_W-1:0] eend_p7;
    logic                  sv;
    logic                  ev;
    logic                  two;
    logic [POS_W-1:0]      plan_lo;
    logic [POS_W-1:0]      plan_hi;
    logic                  plan_close;
    logic                  plan_seg2;
    logic [POS_W-1:0]      seg_len;
    logic [FLS_W-1:0]      fl_sum;
    logic [POS_W-1:0]      ptr_inc;
    logic                  last_byte;
    logic [7:0]            cur_byte;
    logic                  out_free;

    // Footer checks, in priority order
    always_comb
    begin
        if (!full_reg)
            chk_code = ST_SHORT;
        else if (!(^footer_reg))
            chk_code = ST_PARITY;
        else if (footer_reg[FT_HB])
            chk_code = ST_HDRBAD;
        else
            chk_code = ST_OK;
    end

    // Segment plan from the footer fields
    always_comb
    begin
        swo_p7  = {1'b0, footer_reg[FT_SWO +: 4], 2'b00};
        sv      = footer_reg[FT_SV] && (swo_p7 < CHUNK_P7);
        ev      = footer_reg[FT_EV];
        sbo_p7  = sv ? swo_p7 : '0;
        ebo_p7  = {1'b0, footer_reg[FT_EBO +: 6]} + FOOT_POS_W'(1);
        if (!ev || ebo_p7 > CHUNK_P7)
            eend_p7 = CHUNK_P7;
        else
            eend_p7 = ebo_p7;
        two = sv && ev && (eend_p7 <= sbo_p7);

        plan_seg2 = 1'b0;
        if (two && in_frame_reg)
        begin
            plan_lo    = '0;
            plan_hi    = eend_p7[POS_W-1:0];
            plan_close = 1'b1;
            plan_seg2  = 1'b1;
        end
        else if (two)
        begin
            plan_lo    = sbo_p7[POS_W-1:0];
            plan_hi    = CHUNK_POS;
            plan_close = 1'b0;
        end
        else
        begin
            plan_lo    = sbo_p7[POS_W-1:0];
            plan_hi    = eend_p7[POS_W-1:0];
            plan_close = ev;
        end
    end

    assign seg_len   = hi_reg - lo_reg;
    assign fl_sum    = FLS_W'(fl_reg) + FLS_W'(seg_len);
    assign ptr_inc   = ptr_reg + POS_W'(1);
    assign last_byte = (ptr_inc == hi_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.load_ptr)
            ptr_next = lo_reg;
        else if (cmd.emit)
            ptr_next = ptr_inc;
        else
            ptr_next = ptr_reg;
    end

    always_comb
    begin
        case (ptr_reg[1:0])
            2'd0:    cur_byte = rd_data_reg[31:24];
            2'd1:    cur_byte = rd_data_reg[23:16];
            2'd2:    cur_byte = rd_data_reg[15:8];
            default: cur_byte = rd_data_reg[7:0];
        endcase
    end

    always_comb
    begin
        stat.chk_err   = (chk_code != ST_OK);
        stat.no_data   = !footer_reg[FT_DV] || (!in_frame_reg && !sv);
        stat.too_long  = (fl_sum > FLS_W'(max_reg));
        stat.last_byte = last_byte;
        stat.more_seg  = seg2_reg;
        stat.out_free  = out_free;
    end

    // Chunk store: one write port, registered read that follows the pointer
    always_ff @(posedge clk)
    begin
        if (cmd.wr_word && wc_reg < CW_CNT)
            store_mem[wc_reg[STORE_AW-1:0]] <= chunk_word;
        rd_data_reg <= store_mem[ptr_next[STORE_AW+1:2]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_footer)
            footer_reg <= chunk_word;
        if (cmd.load_plan)
        begin
            err_code_reg <= chk_code;
            lo_reg       <= plan_lo;
            hi_reg       <= plan_hi;
            close_reg    <= plan_close;
            seg2_reg     <= plan_seg2;
            sbo_reg      <= sbo_p7[POS_W-1:0];
        end
        else if (cmd.next_seg)
        begin
            lo_reg    <= sbo_reg;
            hi_reg    <= CHUNK_POS;
            close_reg <= 1'b0;
            seg2_reg  <= 1'b0;
        end
        ptr_reg <= ptr_next;
        if (cmd.emit)
        begin
            data_reg   <= cur_byte;
            end_reg    <= last_byte && close_reg;
            status_reg <= ST_OK;
            last_reg   <= last_byte && !seg2_reg;
        end
        else if (cmd.emit_err)
        begin
            data_reg   <= '0;
            end_reg    <= 1'b0;
            status_reg <= cmd.err_long ? ST_LONG : err_code_reg;
            last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= '0;
            full_reg      <= 1'b0;
            in_frame_reg  <= 1'b0;
            fl_reg        <= '0;
            max_reg       <= MAX_FRAME_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_reg <= cfg_wr_data;
            // count words, drop those beyond the chunk
            if (cmd.wr_word && wc_reg < CW_CNT)
                wc_reg <= wc_reg + WC_W'(1);
            else if (cmd.take_footer)
            begin
                full_reg <= (wc_reg == CW_CNT);
                wc_reg   <= '0;
            end
            if (cmd.emit_err)
            begin
                in_frame_reg <= 1'b0;
                fl_reg       <= '0;
            end
            else if (cmd.emit && last_byte)
            begin
                if (close_reg)
                begin
                    in_frame_reg <= 1'b0;
                    fl_reg       <= '0;
                end
                else
                begin
                    in_frame_reg <= 1'b1;
                    fl_reg       <= fl_sum[LEN_W-1:0];
                end
            end
            if (cmd.emit || cmd.emit_err)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_reg;
    assign frame_end = end_reg;
    assign status    = status_reg;
    assign run_last  = last_reg;

    a_hunt_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> fl_reg == '0)
        else $error("frame length nonzero while hunting");

    a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= CW_CNT)
        else $error("word count past chunk size");

    a_emit_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ptr_reg < hi_reg)
        else $error("byte pointer past segment end");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> data_reg == '0 && !end_reg && last_reg)
        else $error("error result carries data or misses run end");

endmodule

>>> rtl/smprd_ctrl.sv
// Controller of the receive chunk deframer: sequences footer check,
// length check, byte emission and error results.
// Depends on smprd_pkg.
`timescale 1ns / 1ps

module smprd_ctrl
    import smprd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        is_footer,
    output logic        in_stall,
    input  smprd_stat_t stat,
    output smprd_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SEGCHK = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_ERR    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !is_footer)
                    cmd.wr_word = 1'b1;
                if (in_valid && is_footer)
                begin
                    cmd.take_footer = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.load_plan = 1'b1;
                if (stat.chk_err)
                    state_next = S_ERR;
                else if (stat.no_data)
                    state_next = S_IDLE;
                else
                    state_next = S_SEGCHK;
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SEGCHK:
            begin
                if (stat.too_long)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_err = 1'b1;
                        cmd.err_long = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.load_ptr = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_byte)
                    begin
                        if (stat.more_seg)
                        begin
                            cmd.next_seg = 1'b1;
                            state_next   = S_SEGCHK;
                        end
                        else
                            state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit || cmd.emit_err |-> stat.out_free)
        else $error("output register overwritten while held");

    a_footer_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_footer |=> state_reg == S_CHECK && in_stall)
        else $error("footer not followed by check");

endmodule

>>> rtl/spi_mac_phy_rx_chunk_deframer_core.sv
// Receive chunk deframer top level: controller plus datapath.
// Depends on smprd_pkg, smprd_ctrl and smprd_dpath.
`timescale 1ns / 1ps

// Flow: payload words are taken back to back while idle. A footer is
//   checked in the check state, then frame bytes leave one per cycle from the
//   chunk store read port while the output is not stalled; a chunk holding
//   two frames passes the segment check once more between its frames. The
//   single byte-wide output register sets the throughput.
// Reset: control state clears, max_frame_bytes returns to 1536, hunting.
//   The chunk store is not cleared; only entries of the current chunk are read.
module spi_mac_phy_rx_chunk_deframer_core
    import smprd_pkg::*;
#(
    parameter int CHUNK_BYTES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    // input words
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       chunk_word,
    input  logic              is_footer,
    // result words
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        data_byte,
    output logic              frame_end,
    output logic [2:0]        status,
    output logic              run_last
);

    smprd_cmd_t  cmd;
    smprd_stat_t stat;

    // Controller: hold the input stalled from footer acceptance until the
    // last result of that footer has been loaded into the output register.
    smprd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_footer (is_footer),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: store payload words, decode the footer, walk the chosen
    // byte range and drive the output word. Payload words beyond the
    // chunk size are dropped here.
    smprd_dpath #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_word  (chunk_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .frame_end   (frame_end),
        .status      (status),
        .run_last    (run_last)
    );

endmodule
